// ===== rtl/core/sha256_byte_stream_hasher_core_defines.svh =====
// Assertion macros used by the SHA-256 core controller.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define SHABSH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("SHA-256 core check failed");

// The consequent must hold in the cycle after the antecedent.
`define SHABSH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SHA-256 core sequencing check failed");

`else

`define SHABSH_ASSERT(lbl, clk, rst, prop)
`define SHABSH_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/shabsh_pkg.sv =====
package shabsh_pkg;

   // Input beat: one message byte with its flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } shabsh_req_type;

   // Result beat: one digest word.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } shabsh_rsp_type;

   // Source of the byte written into the block buffer.
   typedef enum logic [1:0] {
      BSEL_DATA,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LEN
   } shabsh_bsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            put_byte;
      shabsh_bsel_type bsel;
      logic [2:0]      len_idx;
      logic            count_inc;
      logic            load_vars;
      logic            round;
      logic [5:0]      round_idx;
      logic            fold;
      logic            emit;
      logic [2:0]      word_idx;
      logic            restart;
   } shabsh_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_last;
      logic fill_pre_len;
   } shabsh_sts_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_PRE_LEN = 6'd55;

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== rtl/core/shabsh_dp.sv =====
module shabsh_dp import shabsh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  shabsh_req_type req_data,
   input  shabsh_cmd_type cmd,
   output shabsh_sts_type sts,
   output shabsh_rsp_type rsp_data
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0]    hash_ff [8];
   logic [31:0]    hash_in [8];
   logic [31:0]    win_ff [16];
   logic [31:0]    win_in [16];
   logic [31:0]    var_ff [8];
   logic [31:0]    var_in [8];
   logic [5:0]     fill_ff;
   logic [5:0]     fill_in;
   logic [60:0]    count_ff;
   logic [60:0]    count_in;
   shabsh_rsp_type rsp_ff;
   shabsh_rsp_type rsp_in;

   logic [63:0] bit_len;
   logic [7:0]  wr_byte;
   logic [31:0] sig0;
   logic [31:0] sig1;
   logic [31:0] w_next;
   logic [31:0] big0;
   logic [31:0] big1;
   logic [31:0] choose;
   logic [31:0] major;
   logic [31:0] t1;
   logic [31:0] t2;

   // Padding length field: the byte count in bits, most significant byte first.
   assign bit_len = {count_ff, 3'b000};

   // Byte written into the block buffer.
   always_comb begin
      unique case (cmd.bsel)
         BSEL_DATA: wr_byte = req_data.data_byte;
         BSEL_MARK: wr_byte = PAD_MARK;
         BSEL_ZERO: wr_byte = '0;
         BSEL_LEN:  wr_byte = bit_len[{~cmd.len_idx, 3'b000} +: 8];
         default:   wr_byte = '0;
      endcase
   end

   // Message schedule over a sliding window of sixteen words.
   assign sig0   = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
   assign sig1   = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
   assign w_next = win_ff[0] + sig0 + win_ff[9] + sig1;

   // One compression round.
   assign big1   = rotr(var_ff[4], 6) ^ rotr(var_ff[4], 11) ^ rotr(var_ff[4], 25);
   assign choose = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign t1     = var_ff[7] + big1 + choose + ROUND_K[cmd.round_idx] + win_ff[0];
   assign big0   = rotr(var_ff[0], 2) ^ rotr(var_ff[0], 13) ^ rotr(var_ff[0], 22);
   assign major  = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^
                   (var_ff[1] & var_ff[2]);
   assign t2     = big0 + major;

   // Next values of all datapath registers.
   always_comb begin
      hash_in  = hash_ff;
      win_in   = win_ff;
      var_in   = var_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;

      if (cmd.put_byte) begin
         win_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = wr_byte;
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 61'd1;
      end
      if (cmd.load_vars) begin
         var_in = hash_ff;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_next;
         var_in[7]  = var_ff[6];
         var_in[6]  = var_ff[5];
         var_in[5]  = var_ff[4];
         var_in[4]  = var_ff[3] + t1;
         var_in[3]  = var_ff[2];
         var_in[2]  = var_ff[1];
         var_in[1]  = var_ff[0];
         var_in[0]  = t1 + t2;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + var_ff[i];
         end
      end
      if (cmd.emit) begin
         rsp_in.digest_word = hash_ff[cmd.word_idx];
         rsp_in.word_index  = cmd.word_idx;
         rsp_in.last_word   = &cmd.word_idx;
      end
      if (cmd.restart) begin
         hash_in  = HASH_IV;
         count_in = '0;
         fill_in  = '0;
      end
   end

   // Reset restores the initial hash and clears fill and count; buffers are not reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_IV;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      var_ff <= var_in;
      rsp_ff <= rsp_in;
   end

   assign sts.fill_last    = (fill_ff == FILL_LAST);
   assign sts.fill_pre_len = (fill_ff == FILL_PRE_LEN);
   assign rsp_data         = rsp_ff;

endmodule

// ===== rtl/core/shabsh_ctrl.sv =====
`include "sha256_byte_stream_hasher_core_defines.svh"

module shabsh_ctrl import shabsh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  shabsh_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  shabsh_sts_type sts,
   output shabsh_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_INIT,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   shabsh_bsel_type pad_sel_ff;
   shabsh_bsel_type pad_sel_in;
   logic [2:0]      len_idx_ff;
   logic [2:0]      len_idx_in;
   logic [5:0]      round_ff;
   logic [5:0]      round_in;
   logic [2:0]      word_ff;
   logic [2:0]      word_in;
   logic            pend_ff;
   logic            pend_in;
   logic            done_ff;
   logic            done_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [3:0]      work_vec;
   logic            rounds_left;
   logic            last_emit;
   logic            msg_closed;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      pad_sel_in   = pad_sel_ff;
      len_idx_in   = len_idx_ff;
      round_in     = round_ff;
      word_in      = word_ff;
      pend_in      = pend_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.bsel     = BSEL_DATA;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.put_byte  = req_data.byte_present;
               cmd.count_inc = req_data.byte_present;
               pad_sel_in    = BSEL_MARK;
               len_idx_in    = '0;
               done_in       = 1'b0;
               pend_in       = req_data.end_of_message;
               if (req_data.byte_present && sts.fill_last) begin
                  state_in = ST_INIT;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Terminator, zero fill and length, one byte a cycle.
            cmd.put_byte = 1'b1;
            cmd.bsel     = pad_sel_ff;
            cmd.len_idx  = len_idx_ff;
            if (pad_sel_ff == BSEL_LEN) begin
               len_idx_in = len_idx_ff + 3'd1;
               if (&len_idx_ff) begin
                  done_in = 1'b1;
               end
            end else begin
               pad_sel_in = sts.fill_pre_len ? BSEL_LEN : BSEL_ZERO;
            end
            if (sts.fill_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.load_vars = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round     = 1'b1;
            cmd.round_idx = round_ff;
            round_in      = round_ff + 6'd1;
            if (&round_ff) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            word_in  = '0;
            if (done_ff) begin
               state_in = ST_EMIT;
            end else if (pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Load the next digest word once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               cmd.word_idx = word_ff;
               word_in      = word_ff + 3'd1;
               rsp_valid_in = 1'b1;
               if (&word_ff) begin
                  cmd.restart = 1'b1;
                  pend_in     = 1'b0;
                  done_in     = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_sel_ff   <= BSEL_MARK;
         len_idx_ff   <= '0;
         round_ff     <= '0;
         word_ff      <= '0;
         pend_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_sel_ff   <= pad_sel_in;
         len_idx_ff   <= len_idx_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign work_vec    = {cmd.put_byte, cmd.load_vars, cmd.round, cmd.fold};
   assign rounds_left = (state_ff == ST_ROUND) && !(&round_ff);
   assign last_emit   = cmd.emit && (&cmd.word_idx);
   assign msg_closed  = (state_ff == ST_IDLE) && !pend_ff && !done_ff;

   // The datapath is given at most one kind of work in a cycle.
   `SHABSH_ASSERT(a_one_work, clock, reset, $onehot0(work_vec))
   // All 64 rounds run back to back before the fold.
   `SHABSH_ASSERT_NEXT(a_rounds_run, clock, reset, rounds_left, state_ff == ST_ROUND)
   // The eighth digest word closes the message.
   `SHABSH_ASSERT_NEXT(a_last_word_idle, clock, reset, last_emit, msg_closed)

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// Channel   Direction  Payload           Handshake
// req_      in         shabsh_req_type   req_valid / req_ready
// rsp_      out        shabsh_rsp_type   rsp_valid / rsp_ready
//
// A message byte is taken while the sequencer is idle; each full 64-byte block
// then holds the input while the single round unit loads, runs 64 rounds and
// folds. An ending beat adds the padding bytes, one or two further blocks and
// eight output beats. Reset is synchronous and restores the initial hash. A
// stalled output holds the sequencer in the digest state only.
module sha256_byte_stream_hasher_core import shabsh_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  shabsh_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output shabsh_rsp_type rsp_data
);

   shabsh_cmd_type cmd;
   shabsh_sts_type sts;

   // Sequencer.
   shabsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Block buffer, round unit and hash state.
   shabsh_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
module tb_top import shabsh_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 480;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;

   logic           clock;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   shabsh_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   shabsh_rsp_type rsp_data;

   sha256_byte_stream_hasher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Stimulus and scoreboard storage.
   shabsh_req_type pending_beats [$];
   shabsh_rsp_type digest_q [$];
   int             total_beats;
   int             beats_accepted;
   int             words_checked;
   int             messages_hashed;
   int             bytes_hashed;
   int             failures;
   int             quiet_cycles;

   // Running hash state of the predictor.
   logic [31:0] hash_state [8];
   logic [31:0] block_buf [16];
   logic [60:0] byte_total;
   logic [5:0]  block_fill_cnt;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One 64-round compression of the buffered block into the running hash.
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = block_buf[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++)
         v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         s1 = rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25);
         t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
         s0 = rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22);
         t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         hash_state[i] = hash_state[i] + v[i];
   endfunction

   // Big-endian packing of one byte; a full block is compressed at once.
   function automatic void absorb_byte(input logic [7:0] b);
      int idx;
      int sh;
      idx = int'(block_fill_cnt[5:2]);
      sh = 8 * (3 - int'(block_fill_cnt[1:0]));
      if (block_fill_cnt[1:0] == 2'd0)
         block_buf[idx] = {b, 24'h0};
      else
         block_buf[idx] = block_buf[idx] | ({24'h0, b} << sh);
      block_fill_cnt = block_fill_cnt + 6'd1;
      if (block_fill_cnt == 6'd0)
         compress_block();
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++)
         hash_state[i] = HASH_IV[i];
      byte_total = '0;
      block_fill_cnt = '0;
   endfunction

   // Works out the digest words that an accepted input beat causes.
   function automatic void predict_beat(input shabsh_req_type beat);
      logic [63:0]    bit_len;
      shabsh_rsp_type word;
      if (beat.byte_present) begin
         absorb_byte(beat.data_byte);
         byte_total = byte_total + 61'd1;
         bytes_hashed++;
      end
      if (beat.end_of_message) begin
         bit_len = {byte_total, 3'b000};
         absorb_byte(PAD_MARK);
         while (block_fill_cnt != 6'd56)
            absorb_byte(8'h00);
         for (int i = 0; i < 8; i++)
            absorb_byte(bit_len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            word.digest_word = hash_state[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_q.push_back(word);
         end
         messages_hashed++;
         restart_hash();
      end
   endfunction

   task automatic push_beat(input logic [7:0] b, input logic present, input logic eom);
      shabsh_req_type beat;
      beat.data_byte      = b;
      beat.byte_present   = present;
      beat.end_of_message = eom;
      pending_beats.push_back(beat);
   endtask

   // A message of random bytes, optionally closed by a separate end-only beat,
   // with idle beats scattered between the bytes.
   task automatic queue_message(input int n_bytes, input bit split_end, input int noise_pct);
      logic [7:0] b;
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            push_beat(8'($urandom), 1'b0, 1'b0);
         if ($urandom_range(0, 9) == 0)
            b = $urandom_range(0, 1) ? 8'hff : 8'h00;
         else
            b = 8'($urandom);
         push_beat(b, 1'b1, (i == n_bytes - 1) && !split_end);
      end
      if (n_bytes == 0 || split_end)
         push_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   // Stimulus, reset and end of run.
   initial begin
      int stim_items;
      int len;
      bit split_end;

      restart_hash();

      // Directed part: idle beats, the empty message, single extreme bytes,
      // "abc" ended on its last byte and again by an end-only beat, and bytes ff, 00.
      push_beat(8'hff, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0);
      push_beat(8'hff, 1'b0, 1'b1);
      push_beat(8'h00, 1'b1, 1'b1);
      push_beat(8'hff, 1'b1, 1'b1);
      push_beat(8'h61, 1'b1, 1'b0);
      push_beat(8'h62, 1'b1, 1'b0);
      push_beat(8'h63, 1'b1, 1'b1);
      push_beat(8'h61, 1'b1, 1'b0);
      push_beat(8'h62, 1'b1, 1'b0);
      push_beat(8'h5a, 1'b0, 1'b0);
      push_beat(8'h63, 1'b1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b1);
      push_beat(8'hff, 1'b1, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b1);

      // Random messages, weighted towards short ones and towards the lengths
      // where the padding needs one or two final blocks.
      stim_items = pending_beats.size();
      while (stim_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6, 7, 8: len = $urandom_range(0, 12);
            9, 10:                     len = $urandom_range(53, 57);
            11, 12:                    len = $urandom_range(61, 65);
            13, 14:                    len = $urandom_range(13, 52);
            default:                   len = $urandom_range(119, 129);
         endcase
         split_end = ($urandom_range(0, 99) < 30);
         queue_message(len, split_end, 5);
         stim_items = pending_beats.size();
      end
      total_beats = pending_beats.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || digest_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages from %0d bytes in %0d input beats.",
               messages_hashed, bytes_hashed, beats_accepted);
      $display("Checked %0d digest words under three idling patterns.", words_checked);
      if (failures == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // Input driver: holds each beat until it is taken.
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beat(req_data);
            beats_accepted++;
         end
         if (beats_accepted * 3 < total_beats)
            idle_pct = 10;
         else if (beats_accepted * 3 < total_beats * 2)
            idle_pct = 59;
         else
            idle_pct = 0;
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each digest word with the oldest expected one.
   always @(posedge clock) begin
      int             idle_pct;
      shabsh_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (digest_q.size() == 0) begin
               $error("digest word %h arrived with none expected", rsp_data.digest_word);
               failures++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, got %h",
                         want.digest_word, rsp_data.digest_word);
                  failures++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, got %0d",
                         want.word_index, rsp_data.word_index);
                  failures++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %0b, got %0b",
                         want.last_word, rsp_data.last_word);
                  failures++;
               end
            end
         end
         if (beats_accepted * 3 < total_beats)
            idle_pct = 59;
         else if (beats_accepted * 3 < total_beats * 2)
            idle_pct = 10;
         else
            idle_pct = 0;
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a beat.", QUIET_LIMIT);
            $display("tb_top failed");
            $finish;
         end
      end
   end

endmodule
